@@ sv/srl_pkg.sv @@
// srl_pkg: shared types, constants and codes of the session rate limiter
// no dependencies; used by srl_update and session_rate_limiter by scoped names
`timescale 1ns / 1ps

package srl_pkg;

  // session table size and derived index width
  localparam int SESSIONS = 64;
  localparam int IDX_W    = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

  // field widths
  localparam int KIND_W   = 3;
  localparam int SESS_W   = 6;
  localparam int COUNT_W  = 16;
  localparam int TIME_W   = 32;
  localparam int BYTES_W  = 32;
  localparam int TICKS_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // operation kinds
  localparam logic [KIND_W-1:0] KIND_CHECK_SEND  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RECORD_SEND = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CHECK_SNAP  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RECORD_SNAP = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REMOVE      = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_BUDGET   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SNAP_INTERVAL = 2'd2;

  // configuration reset values
  localparam logic [BYTES_W-1:0] BYTE_BUDGET_RST   = 32'd65536;
  localparam logic [TICKS_W-1:0] WINDOW_TICKS_RST  = 16'd1000;
  localparam logic [TICKS_W-1:0] SNAP_INTERVAL_RST = 16'd50;

  // one table entry as stored in the memory
  typedef struct packed {
    logic [BYTES_W-1:0] bytes_sent;
    logic [TIME_W-1:0]  window_start;
    logic [TIME_W-1:0]  last_snapshot;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // decision and write-back of one beat
  typedef struct packed {
    logic               allowed;
    logic [BYTES_W-1:0] bytes;
    logic               wr_en;
    logic               set_vld;
    logic               clr_vld;
    entry_t             wr_data;
  } upd_t;

endpackage

@@ sv/srl_ram.sv @@
// srl_ram: generic single-write, single-read memory with registered read
// no dependencies
`timescale 1ns / 1ps

module srl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/srl_update.sv @@
// srl_update: window restart, budget and snapshot decisions for one beat
// depends on srl_pkg
`timescale 1ns / 1ps

module srl_update (
  input  logic [srl_pkg::KIND_W-1:0]  kind,
  input  logic                        in_range,
  input  logic                        vld,
  input  srl_pkg::entry_t             ent,
  input  logic [srl_pkg::COUNT_W-1:0] count,
  input  logic [srl_pkg::TIME_W-1:0]  now,
  input  logic [srl_pkg::BYTES_W-1:0] budget,
  input  logic [srl_pkg::TICKS_W-1:0] window,
  input  logic [srl_pkg::TICKS_W-1:0] interval,
  output srl_pkg::upd_t               upd
);

  logic [srl_pkg::BYTES_W-1:0] bs0;
  logic [srl_pkg::TIME_W-1:0]  ws0;
  logic [srl_pkg::TIME_W-1:0]  ls0;
  logic [srl_pkg::BYTES_W-1:0] bs1;
  logic [srl_pkg::TIME_W-1:0]  ws1;
  logic                        restart;
  logic                        snap_ok;
  logic [srl_pkg::BYTES_W:0]   sum;
  logic [srl_pkg::BYTES_W-1:0] sat_sum;

  // slot creation values, then window restart, saturating byte sum and snapshot check
  always_comb begin
    bs0     = vld ? ent.bytes_sent    : '0;
    ws0     = vld ? ent.window_start  : now;
    ls0     = vld ? ent.last_snapshot : '0;
    restart = (now - ws0) >= {{(srl_pkg::TIME_W-srl_pkg::TICKS_W){1'b0}}, window};
    bs1     = restart ? '0  : bs0;
    ws1     = restart ? now : ws0;
    sum     = {1'b0, bs1} + {{(srl_pkg::BYTES_W+1-srl_pkg::COUNT_W){1'b0}}, count};
    sat_sum = sum[srl_pkg::BYTES_W] ? '1 : sum[srl_pkg::BYTES_W-1:0];
    snap_ok = (now - ent.last_snapshot) >=
              {{(srl_pkg::TIME_W-srl_pkg::TICKS_W){1'b0}}, interval};
  end

  // per-kind decision and write-back
  always_comb begin
    upd.allowed               = 1'b0;
    upd.bytes                 = vld ? ent.bytes_sent : '0;
    upd.wr_en                 = 1'b0;
    upd.set_vld               = 1'b0;
    upd.clr_vld               = 1'b0;
    upd.wr_data.bytes_sent    = bs1;
    upd.wr_data.window_start  = ws1;
    upd.wr_data.last_snapshot = ls0;
    if (!in_range) begin
      upd.bytes = '0;
    end else begin
      unique case (kind)
        srl_pkg::KIND_CHECK_SEND: begin
          upd.allowed = sum <= {1'b0, budget};
          upd.bytes   = bs1;
          upd.wr_en   = 1'b1;
          upd.set_vld = 1'b1;
        end
        srl_pkg::KIND_RECORD_SEND: begin
          upd.allowed            = 1'b1;
          upd.bytes              = sat_sum;
          upd.wr_en              = 1'b1;
          upd.set_vld            = 1'b1;
          upd.wr_data.bytes_sent = sat_sum;
        end
        srl_pkg::KIND_CHECK_SNAP: begin
          upd.allowed = !vld || snap_ok;
        end
        srl_pkg::KIND_RECORD_SNAP: begin
          upd.allowed               = 1'b1;
          upd.bytes                 = bs1;
          upd.wr_en                 = 1'b1;
          upd.set_vld               = 1'b1;
          upd.wr_data.last_snapshot = now;
        end
        srl_pkg::KIND_REMOVE: begin
          upd.allowed = 1'b1;
          upd.bytes   = '0;
          upd.clr_vld = 1'b1;
        end
        default: begin
          upd.allowed = 1'b0;
        end
      endcase
    end
  end

endmodule

@@ sv/session_rate_limiter.sv @@
// session_rate_limiter: per-session fixed-window byte budget and snapshot interval
// depends on srl_pkg, srl_ram, srl_update
`timescale 1ns / 1ps
//
//  channel | direction | handshake         | payload
//  in      | input     | in_valid/in_stall | in_kind, in_session, in_byte_count, in_now
//  out     | output    | out_valid/out_stall | out_allowed, out_bytes_in_window
//  cfg     | input     | cfg_wr_en         | cfg_index, cfg_wdata
//
//  one beat per cycle while the output is not stalled; a beat reads its slot from
//  the table memory at acceptance, is decided and written back in the decide
//  stage, and is loaded into the output register when the decide stage retires it
//  a one-entry forwarding register covers a read that meets the write of the
//  same slot at one clock edge
//  reset clears the slot valid flops at once, so beats are taken right after reset
//  a stalled output holds the decide stage, which then stalls the input

module session_rate_limiter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [srl_pkg::KIND_W-1:0]      in_kind,
  input  logic [srl_pkg::SESS_W-1:0]      in_session,
  input  logic [srl_pkg::COUNT_W-1:0]     in_byte_count,
  input  logic [srl_pkg::TIME_W-1:0]      in_now,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_allowed,
  output logic [srl_pkg::BYTES_W-1:0]     out_bytes_in_window,
  input  logic                            cfg_wr_en,
  input  logic [srl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [srl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // configuration registers
  logic [srl_pkg::BYTES_W-1:0] budget_r;
  logic [srl_pkg::TICKS_W-1:0] window_r;
  logic [srl_pkg::TICKS_W-1:0] interval_r;

  // decide stage
  logic                          s1_vld_r;
  logic                          s1_vld_nxt;
  logic [srl_pkg::KIND_W-1:0]    s1_kind_r;
  logic [srl_pkg::SESS_W-1:0]    s1_session_r;
  logic [srl_pkg::COUNT_W-1:0]   s1_count_r;
  logic [srl_pkg::TIME_W-1:0]    s1_now_r;
  logic [srl_pkg::IDX_W-1:0]     s1_idx;
  logic                          s1_in_range;
  logic                          s1_fire;
  logic                          in_fire;

  // slot valid flops and forwarding register
  logic [srl_pkg::SESSIONS-1:0]  entry_vld_r;
  logic                          fwd_vld_r;
  logic [srl_pkg::IDX_W-1:0]     fwd_idx_r;
  srl_pkg::entry_t               fwd_data_r;
  logic                          fwd_hit;

  // memory and decision
  logic [srl_pkg::ENTRY_W-1:0]   ram_rd_data;
  srl_pkg::entry_t               cur_ent;
  srl_pkg::upd_t                 upd;
  logic                          ram_wr_en;

  // output register
  logic                          out_valid_r;
  logic                          out_allowed_r;
  logic [srl_pkg::BYTES_W-1:0]   out_bytes_r;

  // handshake
  assign s1_fire  = s1_vld_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_vld_r && !s1_fire;
  assign in_fire  = in_valid && !in_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r   <= srl_pkg::BYTE_BUDGET_RST;
      window_r   <= srl_pkg::WINDOW_TICKS_RST;
      interval_r <= srl_pkg::SNAP_INTERVAL_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        srl_pkg::CFG_BYTE_BUDGET:   budget_r   <= cfg_wdata[srl_pkg::BYTES_W-1:0];
        srl_pkg::CFG_WINDOW_TICKS:  window_r   <= cfg_wdata[srl_pkg::TICKS_W-1:0];
        srl_pkg::CFG_SNAP_INTERVAL: interval_r <= cfg_wdata[srl_pkg::TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  // decide stage control
  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_fire) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  // decide stage payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r    <= in_kind;
      s1_session_r <= in_session;
      s1_count_r   <= in_byte_count;
      s1_now_r     <= in_now;
    end
  end

  assign s1_idx      = srl_pkg::IDX_W'(s1_session_r);
  assign s1_in_range = 32'(s1_session_r) < 32'(srl_pkg::SESSIONS);

  // slot table memory
  srl_ram #(
    .WIDTH (srl_pkg::ENTRY_W),
    .DEPTH (srl_pkg::SESSIONS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (s1_idx),
    .wr_data (upd.wr_data),
    .rd_en   (in_fire),
    .rd_addr (srl_pkg::IDX_W'(in_session)),
    .rd_data (ram_rd_data)
  );

  // forward the latest write over stale read data
  assign fwd_hit = fwd_vld_r && (fwd_idx_r == s1_idx);
  assign cur_ent = fwd_hit ? fwd_data_r : srl_pkg::entry_t'(ram_rd_data);

  srl_update u_update (
    .kind     (s1_kind_r),
    .in_range (s1_in_range),
    .vld      (entry_vld_r[s1_idx]),
    .ent      (cur_ent),
    .count    (s1_count_r),
    .now      (s1_now_r),
    .budget   (budget_r),
    .window   (window_r),
    .interval (interval_r),
    .upd      (upd)
  );

  assign ram_wr_en = s1_fire && upd.wr_en;

  // forwarding register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_vld_r <= 1'b0;
    end else if (ram_wr_en) begin
      fwd_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_wr_en) begin
      fwd_idx_r  <= s1_idx;
      fwd_data_r <= upd.wr_data;
    end
  end

  // slot valid flops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_vld_r <= '0;
    end else if (s1_fire) begin
      if (upd.set_vld) begin
        entry_vld_r[s1_idx] <= 1'b1;
      end else if (upd.clr_vld) begin
        entry_vld_r[s1_idx] <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_allowed_r <= upd.allowed;
      out_bytes_r   <= upd.bytes;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_allowed         = out_allowed_r;
  assign out_bytes_in_window = out_bytes_r;

  // a write or create leaves the slot valid
  a_create_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |=> entry_vld_r[$past(s1_idx)])
    else $error("slot not valid after write-back");

  // a remove leaves the slot invalid and reports zero bytes
  a_remove_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_in_range && s1_kind_r == srl_pkg::KIND_REMOVE) |=>
      (!entry_vld_r[$past(s1_idx)] && out_bytes_in_window == '0 && out_allowed))
    else $error("remove did not clear slot");

  // record beats are always allowed
  a_record_allowed: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_in_range && (s1_kind_r == srl_pkg::KIND_RECORD_SEND ||
      s1_kind_r == srl_pkg::KIND_RECORD_SNAP)) |=> out_allowed)
    else $error("record beat not allowed");

  // a retired beat always lands in the output register
  a_retire_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("retired beat lost");

  // a check send never writes more bytes than it read after restart
  a_check_send_no_add: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_wr_en && s1_kind_r == srl_pkg::KIND_CHECK_SEND) |->
      (upd.wr_data.bytes_sent == upd.bytes))
    else $error("check send changed byte count");

endmodule
